@@ src/sitoa_pkg.sv @@
// Package for the signed integer to decimal ASCII converter.
// Shared widths, character codes and the cell control struct. No dependencies.
`default_nettype none

package sitoa_pkg;

  localparam int VALUE_W     = 64;
  localparam int INT_WIDTH_D = 64;

  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  typedef logic [3:0] digit_t;

  // one-hot-ish command to every digit cell
  typedef struct packed {
    logic clr;
    logic conv;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII text converter, top level.
// Depends on sitoa_pkg and sitoa_cell.
//
// Input channel: in_valid / in_stall / in_value. One request carries a signed
// integer; only the low INT_WIDTH bits of in_value are used.
// Output channel: out_valid / out_stall / out_char_code / out_last. Each
// transfer is one ASCII character, most significant first: an optional '-',
// then the digits without leading zeros; out_last marks the final one.
// Steps per input: double-dabble in a chain of NDIG BCD digit cells (one
// magnitude bit per cycle), then the sign if negative, then the skipped
// leading zeros, then the digits; once back in idle, the next request is
// taken.
// in_stall is high while a number is being converted or emitted; one number
// is worked on at a time.
// A stalled output holds its character; the chain waits until it is taken.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int INT_WIDTH = sitoa_pkg::INT_WIDTH_D
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [sitoa_pkg::VALUE_W-1:0]     in_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [7:0]                        out_char_code,
  output logic                              out_last
);
  import sitoa_pkg::*;

  localparam int NDIG = ((INT_WIDTH - 1) * 31) / 100 + 1;
  localparam int BCW  = (INT_WIDTH > 1) ? $clog2(INT_WIDTH) : 1;
  localparam int DCW  = $clog2(NDIG + 1);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_SIGN, S_SKIP, S_EMIT} state_t;

  state_t               state_r;
  logic [INT_WIDTH-1:0] mag_r;
  logic                 neg_r;
  logic [BCW-1:0]       bit_cnt_r;
  logic [DCW-1:0]       dig_cnt_r;
  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_last_r;

  cell_ctl_t            ctl;
  logic [INT_WIDTH-1:0] x;
  logic                 out_ok;
  logic                 emit;
  logic [NDIG:0]        carry;
  digit_t               digits [NDIG];
  digit_t               top;

  assign x      = in_value[INT_WIDTH-1:0];
  assign out_ok = !out_valid_r || !out_stall;
  assign emit   = ((state_r == S_SIGN) || (state_r == S_EMIT)) && out_ok;
  assign top    = digits[NDIG-1];

  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: ctl.clr   = in_valid;
      S_CONV: ctl.conv  = 1'b1;
      S_SKIP: ctl.shift = (top == '0) && (dig_cnt_r > DCW'(1));
      S_EMIT: ctl.shift = out_ok;
      default: ctl = '0;
    endcase
  end

  assign carry[0] = mag_r[INT_WIDTH-1];

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    sitoa_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (carry[i]),
      .digit_in ((i == 0) ? digit_t'(0) : digits[(i == 0) ? 0 : i - 1]),
      .bit_out  (carry[i+1]),
      .digit    (digits[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            neg_r     <= x[INT_WIDTH-1];
            mag_r     <= x[INT_WIDTH-1] ? (~x + INT_WIDTH'(1)) : x;
            bit_cnt_r <= BCW'(INT_WIDTH - 1);
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          mag_r     <= mag_r << 1;
          bit_cnt_r <= bit_cnt_r - BCW'(1);
          dig_cnt_r <= DCW'(NDIG);
          if (bit_cnt_r == '0) begin
            state_r <= neg_r ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          if (out_ok) begin
            out_char_r  <= CH_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (ctl.shift) begin
            dig_cnt_r <= dig_cnt_r - DCW'(1);
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ok) begin
            out_char_r  <= CH_ZERO + {4'b0000, top};
            out_last_r  <= (dig_cnt_r == DCW'(1));
            dig_cnt_r   <= dig_cnt_r - DCW'(1);
            if (dig_cnt_r == DCW'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

@@ src/sitoa_cell.sv @@
// One BCD digit cell of the double-dabble chain.
// Depends on sitoa_pkg (digit_t, cell_ctl_t).
`default_nettype none

module sitoa_cell (
  input  wire                   clk,
  input  sitoa_pkg::cell_ctl_t  ctl,
  input  wire                   bit_in,
  input  sitoa_pkg::digit_t     digit_in,
  output logic                  bit_out,
  output sitoa_pkg::digit_t     digit
);
  import sitoa_pkg::*;

  digit_t digit_r, digit_nxt;
  digit_t adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
    bit_out = adj[3];
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.conv) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule

`default_nettype wire
